[hw/rtl/bfha_pkg.sv]
// shared constants and types for the best-fit heap allocator
`default_nettype none
package bfha_pkg;
	localparam int MAX_BLOCKS_D    = 64;
	localparam int PAGE_BYTES_D    = 4096;
	localparam int MAX_PAGES_D     = 16;
	localparam int HEADER_BYTES_D  = 32;
	localparam int MANAGER_BYTES_D = 40;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	localparam logic CFG_SPLIT_LIMIT = 1'b0;
	localparam logic CFG_PAGE_LIMIT  = 1'b1;
endpackage
`default_nettype wire

[hw/rtl/best_fit_heap_allocator.sv]
// best-fit heap allocator: block table in one memory, sequenced scan and update
//
// Usage: pulse start with command, request_bytes and payload_address while busy
// is low; the command is taken at that edge and busy rises. When the command is
// finished, done is high for one cycle with status and granted_address, and busy
// falls in the cycle after the done pulse. The receiver cannot stall; a result is shown once.
// Configuration: cfg_we with cfg_index (0 split_limit, 1 heap_page_limit) and
// cfg_wdata, written only while busy is low; this binds the user, the block does not enforce it.
// Sequencing: an allocate walks the block list once, a memory read then a
// compare for each block; a free walks until the address matches, then merges
// the left and right free neighbors one block at a time with a read-modify-write
// of the block record. A page count on append is found by a counting loop, one
// page a cycle.
// Reset: the list is empty, all slots are spare, no pages are held, registers
// return to split_limit 256 and heap_page_limit 16; no clearing pass is needed.
`default_nettype none
module best_fit_heap_allocator #(
	parameter int MAX_BLOCKS    = bfha_pkg::MAX_BLOCKS_D,
	parameter int PAGE_BYTES    = bfha_pkg::PAGE_BYTES_D,
	parameter int MAX_PAGES     = bfha_pkg::MAX_PAGES_D,
	parameter int HEADER_BYTES  = bfha_pkg::HEADER_BYTES_D,
	parameter int MANAGER_BYTES = bfha_pkg::MANAGER_BYTES_D
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        command,
	input  wire logic [15:0] request_bytes,
	input  wire logic [15:0] payload_address,
	output logic             done,
	output logic [1:0]       status,
	output logic [15:0]      granted_address,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_wdata
);
	import bfha_pkg::*;

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int PW = $clog2(MAX_PAGES + 1);
	localparam int AW = 18;

	typedef struct packed {
		logic [15:0]   start;
		logic [15:0]   size;
		logic          free;
		logic [IW:0]   next;
		logic [IW:0]   prev;
	} rec_t;

	typedef enum logic [16:0] {
		S_IDLE   = 17'h00001,
		S_SRD    = 17'h00002,
		S_SCHK   = 17'h00004,
		S_BEST   = 17'h00008,
		S_SPLIT  = 17'h00010,
		S_SPNX   = 17'h00020,
		S_APRD   = 17'h00040,
		S_APCHK  = 17'h00080,
		S_GROW   = 17'h00100,
		S_APWR   = 17'h00200,
		S_FRD    = 17'h00400,
		S_FCHK   = 17'h00800,
		S_LRD    = 17'h01000,
		S_LCHK   = 17'h02000,
		S_RRD    = 17'h04000,
		S_RCHK   = 17'h08000,
		S_FIN    = 17'h10000
	} state_t;

	state_t state_q;
	rec_t mem [MAX_BLOCKS];
	rec_t rd_q;
	logic we;
	logic [IW-1:0] waddr, raddr;
	rec_t wdata;
	logic re;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rd_q <= mem[raddr];
	end

	logic [15:0] split_limit_q;
	logic [4:0]  page_limit_q;
	logic [IW:0] first_q, last_q, cur_q, best_q, tgt_q, spl_q;
	logic [15:0] best_size_q, req_q, addr_q;
	logic        cmd_q;
	logic [IW:0] steps_q;
	logic [MAX_BLOCKS-1:0] spare_q;
	logic [PW-1:0] pages_q, grow_q;
	logic [AW-1:0] tail_end_q;
	rec_t hold_q;
	logic [1:0] status_q;
	logic [15:0] grant_q;

	// lowest spare slot
	logic [IW:0] slot;
	always_comb begin
		slot = (IW+1)'(MAX_BLOCKS);
		for (int i = MAX_BLOCKS - 1; i >= 0; i--)
			if (spare_q[i]) slot = (IW+1)'(i);
	end

	wire [IW:0] none = (IW+1)'(MAX_BLOCKS);
	wire [AW-1:0] need = AW'(req_q) + AW'(HEADER_BYTES);
	wire [AW-1:0] bsz = AW'(rd_q.size);
	wire [AW-1:0] new_end = tail_end_q + need;
	wire [AW+PW-1:0] heap_end_w = (AW+PW)'(pages_q) * (AW+PW)'(PAGE_BYTES);
	wire [PW:0] plimit = (5'(page_limit_q) < 5'(MAX_PAGES) || MAX_PAGES > 31)
		? (PW+1)'(page_limit_q) : (PW+1)'(MAX_PAGES);

	// append checks: growth covers both the new end and the whole new block
	wire [AW+PW-1:0] grow_bytes = (AW+PW)'(grow_q) * (AW+PW)'(PAGE_BYTES);
	wire ap_bad = slot == none || new_end > AW'(65536) ||
		tail_end_q + AW'(HEADER_BYTES) > AW'(65535);
	wire past_heap = (AW+PW)'(new_end) > heap_end_w;
	wire ap_short = (AW+PW)'(new_end) > heap_end_w + grow_bytes ||
		(past_heap && (AW+PW)'(need) > grow_bytes);
	wire [PW:0] pages_sum = (PW+1)'(pages_q) + (PW+1)'(grow_q);
	wire ap_ok = !ap_bad && !ap_short && pages_sum <= plimit;

	always_comb begin
		we = 1'b0; waddr = cur_q[IW-1:0]; wdata = rd_q;
		re = 1'b0; raddr = cur_q[IW-1:0];
		case (state_q)
			S_SRD, S_FRD, S_LRD, S_RRD, S_APRD: re = 1'b1;
			default: ;
		endcase
		case (state_q)
			S_BEST: begin
				we = 1'b1; waddr = best_q[IW-1:0]; wdata = rd_q; wdata.free = 1'b0;
				if (bsz >= need && bsz - need > AW'(split_limit_q) && slot != none) begin
					wdata.size = req_q; wdata.next = slot;
				end
			end
			S_SPLIT: begin
				we = 1'b1; waddr = spl_q[IW-1:0]; wdata = hold_q;
			end
			S_SPNX: begin
				we = 1'b1; waddr = cur_q[IW-1:0]; wdata = rd_q; wdata.prev = spl_q;
			end
			S_GROW: if (ap_ok) begin
				we = 1'b1; waddr = slot[IW-1:0];
				wdata.start = tail_end_q[15:0]; wdata.size = req_q; wdata.free = 1'b0;
				wdata.next = none; wdata.prev = last_q;
			end
			S_APWR: begin
				// cur_q still names the old tail
				if (cur_q != none) begin
					we = 1'b1; waddr = cur_q[IW-1:0]; wdata = rd_q; wdata.next = spl_q;
				end
			end
			S_FCHK: if (16'(rd_q.start + 16'(HEADER_BYTES)) == addr_q &&
					{1'b0, rd_q.start} + 17'(HEADER_BYTES) < 17'h10000 && !rd_q.free) begin
				we = 1'b1; wdata.free = 1'b1;
			end
			S_RCHK: begin
				we = 1'b1; waddr = tgt_q[IW-1:0]; wdata = hold_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			split_limit_q <= 16'd256;
			page_limit_q <= 5'd16;
			first_q <= (IW+1)'(MAX_BLOCKS);
			last_q <= (IW+1)'(MAX_BLOCKS);
			spare_q <= '1;
			pages_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					CFG_SPLIT_LIMIT: split_limit_q <= cfg_wdata;
					CFG_PAGE_LIMIT:  page_limit_q <= cfg_wdata[4:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: if (start && !done) begin
					cmd_q <= command; req_q <= request_bytes; addr_q <= payload_address;
					cur_q <= first_q; steps_q <= '0; best_q <= none;
					state_q <= (command == CMD_FREE) ? S_FRD : S_SRD;
				end
				S_SRD: begin
					if (cur_q == none || steps_q == none) begin
						if (best_q != none) begin cur_q <= best_q; state_q <= S_APRD; end
						else begin cur_q <= last_q; state_q <= S_APRD; end
					end else state_q <= S_SCHK;
				end
				S_SCHK: begin
					if (rd_q.free && rd_q.size >= req_q &&
						(best_q == none || rd_q.size < best_size_q)) begin
						best_q <= cur_q; best_size_q <= rd_q.size;
					end
					cur_q <= rd_q.next; steps_q <= steps_q + 1'b1;
					state_q <= S_SRD;
				end
				S_APRD: state_q <= (best_q != none) ? S_BEST : S_APCHK;
				S_BEST: begin
					status_q <= ST_DONE;
					grant_q <= rd_q.start + 16'(HEADER_BYTES);
					if (bsz >= need && bsz - need > AW'(split_limit_q) && slot != none) begin
						spl_q <= slot; spare_q[slot[IW-1:0]] <= 1'b0;
						hold_q.start <= 16'(AW'(rd_q.start) + need);
						hold_q.size <= 16'(bsz - need);
						hold_q.free <= 1'b1; hold_q.prev <= best_q; hold_q.next <= rd_q.next;
						tgt_q <= rd_q.next;
						state_q <= S_SPLIT;
					end else state_q <= S_FIN;
				end
				S_SPLIT: begin
					if (tgt_q == none) begin last_q <= spl_q; state_q <= S_FIN; end
					else begin cur_q <= tgt_q; state_q <= S_RRD; cmd_q <= CMD_ALLOC; end
				end
				S_APCHK: begin
					tail_end_q <= (last_q != none) ?
						AW'(rd_q.start) + AW'(HEADER_BYTES) + AW'(rd_q.size) :
						AW'(MANAGER_BYTES);
					grow_q <= '0; state_q <= S_GROW;
				end
				S_GROW: begin
					// count pages until the heap covers the new end
					if (ap_bad) begin
						status_q <= ST_NOSPACE; grant_q <= '0; state_q <= S_FIN;
					end else if (ap_short) begin
						if (pages_sum >= plimit) begin
							status_q <= ST_NOSPACE; grant_q <= '0; state_q <= S_FIN;
						end else grow_q <= grow_q + 1'b1;
					end else if (pages_sum > plimit) begin
						status_q <= ST_NOSPACE; grant_q <= '0; state_q <= S_FIN;
					end else begin
						pages_q <= pages_q + grow_q;
						spl_q <= slot; spare_q[slot[IW-1:0]] <= 1'b0;
						if (last_q == none) first_q <= slot;
						last_q <= slot;
						status_q <= ST_DONE; grant_q <= 16'(tail_end_q + AW'(HEADER_BYTES));
						state_q <= S_APWR;
					end
				end
				S_APWR: state_q <= S_FIN;
				S_FRD: begin
					if (cur_q == none || steps_q == none) begin
						status_q <= ST_IGNORED; grant_q <= '0; state_q <= S_FIN;
					end else state_q <= S_FCHK;
				end
				S_FCHK: begin
					if (16'(rd_q.start + 16'(HEADER_BYTES)) == addr_q &&
						{1'b0, rd_q.start} + 17'(HEADER_BYTES) < 17'h10000) begin
						if (rd_q.free) begin
							status_q <= ST_IGNORED; grant_q <= '0; state_q <= S_FIN;
						end else begin
							status_q <= ST_DONE; grant_q <= '0;
							hold_q <= '{start: rd_q.start, size: rd_q.size, free: 1'b1,
								next: rd_q.next, prev: rd_q.prev};
							tgt_q <= cur_q;
							if (rd_q.prev != none) begin cur_q <= rd_q.prev; state_q <= S_LRD; end
							else begin cur_q <= rd_q.next; state_q <= S_RRD; end
						end
					end else begin
						cur_q <= rd_q.next; steps_q <= steps_q + 1'b1; state_q <= S_FRD;
					end
				end
				S_LRD: state_q <= S_LCHK;
				S_LCHK: begin
					if (rd_q.free) begin
						tgt_q <= cur_q; hold_q <= rd_q;
						if (rd_q.prev != none) begin cur_q <= rd_q.prev; state_q <= S_LRD; end
						else begin cur_q <= rd_q.next; state_q <= S_RRD; end
					end else begin
						cur_q <= hold_q.next; state_q <= S_RRD;
					end
				end
				S_RRD: begin
					if (cmd_q == CMD_ALLOC) state_q <= S_SPNX;
					else if (hold_q.next == none) state_q <= S_RCHK;
					else begin cur_q <= hold_q.next; state_q <= S_RCHK; end
				end
				S_SPNX: state_q <= S_FIN;
				S_RCHK: begin
					// hold_q is the merged record at tgt_q, written each pass
					if (hold_q.next != none && rd_q.free) begin
						hold_q.size <= hold_q.size + 16'(HEADER_BYTES) + rd_q.size;
						hold_q.next <= rd_q.next;
						spare_q[cur_q[IW-1:0]] <= 1'b1;
						cur_q <= rd_q.next;
						state_q <= S_RRD;
					end else begin
						if (hold_q.next == none) last_q <= tgt_q;
						else begin
							cur_q <= hold_q.next; spl_q <= tgt_q;
							cmd_q <= CMD_ALLOC; state_q <= S_RRD;
						end
						if (hold_q.next == none) state_q <= S_FIN;
					end
				end
				S_FIN: begin
					done <= 1'b1; status <= status_q; granted_address <= grant_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE) || done;
endmodule
`default_nettype wire
